FILE: sv/kvpt_pkg.sv
// ----------------------------------------------------------------------------
// Key/value pair tokenizer package
// Shared types, character constants and value limits for the key/value pair tokenizer.
// ----------------------------------------------------------------------------
package kvpt_pkg;

  typedef enum logic [7:0] {
    PH_KEY_QUOTE   = 8'b0000_0001,
    PH_KEY_BODY    = 8'b0000_0010,
    PH_COLON       = 8'b0000_0100,
    PH_VALUE_START = 8'b0000_1000,
    PH_NUMBER      = 8'b0001_0000,
    PH_NULL        = 8'b0010_0000,
    PH_STRING      = 8'b0100_0000,
    PH_ERROR       = 8'b1000_0000
  } phase_t;

  typedef enum logic [2:0] {
    TK_KEY_CHAR = 3'd0,
    TK_KEY_END  = 3'd1,
    TK_STR_CHAR = 3'd2,
    TK_STR_END  = 3'd3,
    TK_NUMBER   = 3'd4,
    TK_NULL     = 3'd5,
    TK_ERROR    = 3'd6
  } token_kind_t;

  typedef enum logic [1:0] {
    ERR_KEY_QUOTE   = 2'd0,
    ERR_COLON       = 2'd1,
    ERR_VALUE_QUOTE = 2'd2
  } error_code_t;

  localparam logic [7:0] CH_QUOTE     = 8'h22;
  localparam logic [7:0] CH_COLON     = 8'h3A;
  localparam logic [7:0] CH_UPPER_N   = 8'h4E;
  localparam logic [7:0] CH_LOWER_N   = 8'h6E;
  localparam logic [7:0] CH_COMMA     = 8'h2C;
  localparam logic [7:0] CH_RBRACE    = 8'h7D;
  localparam logic [7:0] CH_BACKSLASH = 8'h5C;
  localparam logic [7:0] CH_SPACE     = 8'h20;
  localparam logic [7:0] CH_TAB       = 8'h09;
  localparam logic [7:0] CH_CR        = 8'h0D;
  localparam logic [7:0] CH_ZERO      = 8'h30;
  localparam logic [7:0] CH_NINE      = 8'h39;

  localparam logic signed [31:0] NULL_VALUE = -32'sd1;
  localparam logic [30:0]        NUM_MAX    = 31'h7FFF_FFFF;

endpackage

FILE: sv/kvpt_if.sv
// ----------------------------------------------------------------------------
// Key/value pair tokenizer channels
// Valid/ready channels for input bytes and for output tokens.
// ----------------------------------------------------------------------------
interface kvpt_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink (input valid, input in_byte, output ready);
endinterface

interface kvpt_out_if import kvpt_pkg::*; ;
  logic               valid;
  logic               ready;
  logic [2:0]         token_kind;
  logic [7:0]         char_out;
  logic signed [31:0] number_value;
  logic               overflowed;
  logic [1:0]         error_code;

  modport source (output valid, output token_kind, output char_out,
                  output number_value, output overflowed, output error_code,
                  input ready);
  modport sink (input valid, input token_kind, input char_out,
                input number_value, input overflowed, input error_code,
                output ready);
endinterface

FILE: sv/key_value_pair_tokenizer.sv
// ----------------------------------------------------------------------------
// Key/value pair tokenizer
// Byte-serial lexer for "key": value pairs with number, null and string values.
// ----------------------------------------------------------------------------
// One byte enters on in_chan per request and produces zero or one token on
// out_chan. Both channels use valid/ready; a request moves when both are high.
// An accepted byte is held in an input register, is lexed by the combinational
// step logic and its token lands in the output register that drives out_chan.
// A byte can be accepted every cycle while the receiver does not stall. Bytes
// that make no token, such as skipped whitespace or digits of a number, pass
// through the input register and leave no output.
// When the receiver stalls, the output register holds its token and the input
// register holds the next byte; in_chan.ready drops only when both are full.
// A synchronous active-low reset empties both registers and returns the lexer
// to waiting for the opening quote of a key. After an error token every byte
// is accepted and dropped until the next reset.
// ----------------------------------------------------------------------------
module key_value_pair_tokenizer import kvpt_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  kvpt_in_if.sink   in_chan,
  kvpt_out_if.source out_chan
);

  logic               in_valid_r;
  logic [7:0]         byte_r;
  phase_t             phase_r, phase_nxt;
  logic [30:0]        acc_r, acc_nxt;
  logic               sat_r, sat_nxt;
  logic               esc_r, esc_nxt;

  logic               out_valid_r;
  logic [2:0]         kind_r, kind_nxt;
  logic [7:0]         char_r, char_nxt;
  logic signed [31:0] value_r, value_nxt;
  logic               ovf_r, ovf_nxt;
  logic [1:0]         code_r, code_nxt;
  logic               emit_nxt;

  logic               advance;
  logic               is_blank;
  logic               is_digit;
  logic [34:0]        prod;

  assign advance         = in_valid_r && (!out_valid_r || out_chan.ready);
  assign in_chan.ready   = !in_valid_r || advance;
  assign is_blank        = (byte_r == CH_SPACE) || (byte_r >= CH_TAB && byte_r <= CH_CR);
  assign is_digit        = (byte_r >= CH_ZERO) && (byte_r <= CH_NINE);
  assign prod            = {1'b0, acc_r, 3'b000} + {3'b000, acc_r, 1'b0}
                           + {31'd0, byte_r[3:0]};

  always_comb begin
    phase_nxt = phase_r;
    acc_nxt   = acc_r;
    sat_nxt   = sat_r;
    esc_nxt   = esc_r;
    emit_nxt  = 1'b0;
    kind_nxt  = TK_KEY_CHAR;
    char_nxt  = 8'd0;
    value_nxt = 32'sd0;
    ovf_nxt   = 1'b0;
    code_nxt  = ERR_KEY_QUOTE;
    unique case (phase_r)
      PH_KEY_QUOTE: begin
        if (!is_blank) begin
          if (byte_r == CH_QUOTE) begin
            phase_nxt = PH_KEY_BODY;
          end else begin
            phase_nxt = PH_ERROR;
            emit_nxt  = 1'b1;
            kind_nxt  = TK_ERROR;
            code_nxt  = ERR_KEY_QUOTE;
          end
        end
      end
      PH_KEY_BODY: begin
        emit_nxt = 1'b1;
        if (byte_r == CH_QUOTE) begin
          phase_nxt = PH_COLON;
          kind_nxt  = TK_KEY_END;
        end else begin
          kind_nxt = TK_KEY_CHAR;
          char_nxt = byte_r;
        end
      end
      PH_COLON: begin
        if (!is_blank) begin
          if (byte_r == CH_COLON) begin
            phase_nxt = PH_VALUE_START;
          end else begin
            phase_nxt = PH_ERROR;
            emit_nxt  = 1'b1;
            kind_nxt  = TK_ERROR;
            code_nxt  = ERR_COLON;
          end
        end
      end
      PH_VALUE_START: begin
        if (!is_blank) begin
          if (is_digit) begin
            acc_nxt   = {27'd0, byte_r[3:0]};
            sat_nxt   = 1'b0;
            phase_nxt = PH_NUMBER;
          end else if (byte_r == CH_UPPER_N || byte_r == CH_LOWER_N) begin
            phase_nxt = PH_NULL;
          end else if (byte_r == CH_QUOTE) begin
            esc_nxt   = 1'b0;
            phase_nxt = PH_STRING;
          end else begin
            phase_nxt = PH_ERROR;
            emit_nxt  = 1'b1;
            kind_nxt  = TK_ERROR;
            code_nxt  = ERR_VALUE_QUOTE;
          end
        end
      end
      PH_NUMBER: begin
        if (is_digit) begin
          if (sat_r || (prod[34:31] != 4'd0)) begin
            acc_nxt = NUM_MAX;
            sat_nxt = 1'b1;
          end else begin
            acc_nxt = prod[30:0];
          end
        end else begin
          phase_nxt = PH_KEY_QUOTE;
          acc_nxt   = 31'd0;
          sat_nxt   = 1'b0;
          emit_nxt  = 1'b1;
          kind_nxt  = TK_NUMBER;
          char_nxt  = byte_r;
          value_nxt = signed'({1'b0, acc_r});
          ovf_nxt   = sat_r;
        end
      end
      PH_NULL: begin
        if (byte_r == CH_COMMA || byte_r == CH_RBRACE) begin
          phase_nxt = PH_KEY_QUOTE;
          emit_nxt  = 1'b1;
          kind_nxt  = TK_NULL;
          char_nxt  = byte_r;
          value_nxt = NULL_VALUE;
        end
      end
      PH_STRING: begin
        emit_nxt = 1'b1;
        if (esc_r) begin
          esc_nxt  = 1'b0;
          kind_nxt = TK_STR_CHAR;
          char_nxt = byte_r;
        end else if (byte_r == CH_BACKSLASH) begin
          esc_nxt  = 1'b1;
          kind_nxt = TK_STR_CHAR;
          char_nxt = byte_r;
        end else if (byte_r == CH_QUOTE) begin
          phase_nxt = PH_KEY_QUOTE;
          kind_nxt  = TK_STR_END;
        end else begin
          kind_nxt = TK_STR_CHAR;
          char_nxt = byte_r;
        end
      end
      PH_ERROR: begin
        emit_nxt = 1'b0;
      end
      default: begin
        phase_nxt = PH_ERROR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      phase_r     <= PH_KEY_QUOTE;
      acc_r       <= 31'd0;
      sat_r       <= 1'b0;
      esc_r       <= 1'b0;
    end else begin
      if (in_chan.valid && in_chan.ready) begin
        in_valid_r <= 1'b1;
      end else if (advance) begin
        in_valid_r <= 1'b0;
      end
      if (advance) begin
        out_valid_r <= emit_nxt;
        phase_r     <= phase_nxt;
        acc_r       <= acc_nxt;
        sat_r       <= sat_nxt;
        esc_r       <= esc_nxt;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_chan.valid && in_chan.ready) begin
      byte_r <= in_chan.in_byte;
    end
    if (advance) begin
      kind_r  <= kind_nxt;
      char_r  <= char_nxt;
      value_r <= value_nxt;
      ovf_r   <= ovf_nxt;
      code_r  <= code_nxt;
    end
  end

  assign out_chan.valid        = out_valid_r;
  assign out_chan.token_kind   = kind_r;
  assign out_chan.char_out     = char_r;
  assign out_chan.number_value = value_r;
  assign out_chan.overflowed   = ovf_r;
  assign out_chan.error_code   = code_r;

endmodule
